[sv/rpf_pkg.sv]
// Shared types and constants for the RGB pixel filter.
// Holds the channel payload structs, mode codes, register indexes and fixed coefficients.
// No dependencies.
`default_nettype none

package rpf_pkg;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } result_t;

  typedef struct packed {
    logic [7:0] pass;
    logic [7:0] dim;
    logic [7:0] bright;
  } lane_t;

  typedef struct packed {
    logic [7:0] lum;
    logic [7:0] left;
    logic [7:0] above;
  } nbr_t;

  typedef struct packed {
    logic col_odd;
    logic grid_keep;
  } pos_t;

  localparam logic [3:0] MODE_COPY        = 4'd0;
  localparam logic [3:0] MODE_RED_GRAY    = 4'd1;
  localparam logic [3:0] MODE_GREEN_GRAY  = 4'd2;
  localparam logic [3:0] MODE_BLUE_GRAY   = 4'd3;
  localparam logic [3:0] MODE_LUMA_GRAY   = 4'd4;
  localparam logic [3:0] MODE_DIM         = 4'd5;
  localparam logic [3:0] MODE_BRIGHTEN    = 4'd6;
  localparam logic [3:0] MODE_GREEN_ONLY  = 4'd7;
  localparam logic [3:0] MODE_ODD_BLANK   = 4'd8;
  localparam logic [3:0] MODE_THIRD_GRID  = 4'd9;
  localparam logic [3:0] MODE_VERT_EDGE   = 4'd10;
  localparam logic [3:0] MODE_HORIZ_EDGE  = 4'd11;

  localparam logic [1:0] CFG_MODE      = 2'd0;
  localparam logic [1:0] CFG_WIDTH     = 2'd1;
  localparam logic [1:0] CFG_MAX_COLOR = 2'd2;
  localparam logic [1:0] CFG_THRESHOLD = 2'd3;

  localparam logic [3:0]  MODE_RESET      = MODE_COPY;
  localparam logic [10:0] WIDTH_RESET     = 11'd640;
  localparam logic [7:0]  MAX_COLOR_RESET = 8'd255;
  localparam logic [7:0]  THRESH_RESET    = 8'd25;

  localparam logic [15:0] LUMA_R_Q16 = 16'd13933;
  localparam logic [15:0] LUMA_G_Q16 = 16'd46871;
  localparam logic [15:0] LUMA_B_Q16 = 16'd4732;

  localparam logic [7:0] DIM_STEP      = 8'd20;
  localparam logic [8:0] BRIGHT_OFFSET = 9'd50;

endpackage

`default_nettype wire

[sv/rpf_lane.sv]
// One color channel lane of the RGB pixel filter.
// Forms the channel's luma term and registers its pass, dim and brighten values.
// Depends on rpf_pkg.
`default_nettype none

module rpf_lane (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire logic [7:0]    x,
  input  wire logic [15:0]   coef,
  input  wire logic [7:0]    max_color,
  output logic      [7:0]    term,
  output rpf_pkg::lane_t     q
);

  logic [23:0] prod;
  logic [7:0]  dim_val;
  logic [8:0]  bright_sum;
  logic [7:0]  bright_val;

  always_comb begin
    prod = 24'(x) * 24'(coef);
    term = prod[23:16];
    dim_val = (x > rpf_pkg::DIM_STEP) ? (x - rpf_pkg::DIM_STEP) : 8'd0;
    bright_sum = {1'b0, x} + {2'b00, x[7:1]} + rpf_pkg::BRIGHT_OFFSET;
    bright_val = (bright_sum > {1'b0, max_color}) ? max_color : bright_sum[7:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q.pass   <= x;
      q.dim    <= dim_val;
      q.bright <= bright_val;
    end
  end

endmodule

`default_nettype wire

[sv/rpf_linestore.sv]
// Line store of luma values for the row above, one entry per column.
// Registered read with bypass of a same-address write in the same cycle.
// No package dependencies.
`default_nettype none

module rpf_linestore #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;
  logic [7:0] byp_q;
  logic       byp_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q   <= mem[rd_addr];
      byp_q   <= wr_data;
      byp_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_hit ? byp_q : mem_q;

endmodule

`default_nettype wire

[sv/rpf_merge.sv]
// Merging stage of the RGB pixel filter.
// Combines the three lane results, luma and neighbor luma by mode into the output register.
// Depends on rpf_pkg.
`default_nettype none

module rpf_merge (
  input  wire logic            clk,
  input  wire logic            load,
  input  wire logic [3:0]      mode,
  input  wire logic [7:0]      max_color,
  input  wire logic [7:0]      edge_threshold,
  input  wire rpf_pkg::lane_t  red,
  input  wire rpf_pkg::lane_t  green,
  input  wire rpf_pkg::lane_t  blue,
  input  wire rpf_pkg::nbr_t   nbr,
  input  wire rpf_pkg::pos_t   pos,
  output rpf_pkg::result_t     res
);

  logic [7:0] diff_left;
  logic [7:0] diff_above;
  logic [7:0] edge_left;
  logic [7:0] edge_above;
  rpf_pkg::result_t sel;

  always_comb begin
    diff_left  = (nbr.left > nbr.lum) ? (nbr.left - nbr.lum) : (nbr.lum - nbr.left);
    diff_above = (nbr.above > nbr.lum) ? (nbr.above - nbr.lum) : (nbr.lum - nbr.above);
    edge_left  = (diff_left > edge_threshold) ? max_color : 8'd0;
    edge_above = (diff_above > edge_threshold) ? max_color : 8'd0;

    case (mode)
      rpf_pkg::MODE_RED_GRAY:   sel = '{red.pass, red.pass, red.pass};
      rpf_pkg::MODE_GREEN_GRAY: sel = '{green.pass, green.pass, green.pass};
      rpf_pkg::MODE_BLUE_GRAY:  sel = '{blue.pass, blue.pass, blue.pass};
      rpf_pkg::MODE_LUMA_GRAY:  sel = '{nbr.lum, nbr.lum, nbr.lum};
      rpf_pkg::MODE_DIM:        sel = '{red.dim, green.dim, blue.dim};
      rpf_pkg::MODE_BRIGHTEN:   sel = '{red.bright, green.bright, blue.bright};
      rpf_pkg::MODE_GREEN_ONLY: sel = '{8'd0, green.pass, 8'd0};
      rpf_pkg::MODE_ODD_BLANK: begin
        if (pos.col_odd) begin
          sel = '{8'd0, 8'd0, 8'd0};
        end else begin
          sel = '{red.pass, green.pass, blue.pass};
        end
      end
      rpf_pkg::MODE_THIRD_GRID: begin
        if (pos.grid_keep) begin
          sel = '{red.pass, green.pass, blue.pass};
        end else begin
          sel = '{8'd0, 8'd0, 8'd0};
        end
      end
      rpf_pkg::MODE_VERT_EDGE:  sel = '{edge_left, edge_left, edge_left};
      rpf_pkg::MODE_HORIZ_EDGE: sel = '{edge_above, edge_above, edge_above};
      default:                  sel = '{red.pass, green.pass, blue.pass};
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= sel;
    end
  end

endmodule

`default_nettype wire

[sv/rgb_pixel_filter_multimode_top.sv]
// Top level of the RGB pixel filter: raster position tracking, pipeline control and config.
// Instantiates three rpf_lane, rpf_linestore and rpf_merge; depends on rpf_pkg.
//
//   Channel  Signals                               Direction  Moves
//   px       px_valid, px_stall, px                in         one pixel request
//   res      res_valid, res_stall, res             out        one result pixel
//   cfg      cfg_valid, cfg_ready, cfg_index/data  in         one register write
//
// One pixel is accepted per clock while px_stall is low; it passes s1, s2 and the res register.
// The line store takes one read and one write per cycle, so it sets no limit below one per clock.
// Reset clears position, pipeline valids and registers; the line store is not cleared.
// A stalled output holds only the stages that are full; empty stages still take requests.
`default_nettype none

module rgb_pixel_filter_multimode_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              px_valid,
  output logic                   px_stall,
  input  wire rpf_pkg::pixel_t   px,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output rpf_pkg::result_t       res,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [10:0]       cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [3:0]  mode;
  logic [10:0] image_width;
  logic [7:0]  max_color;
  logic [7:0]  edge_threshold;

  logic [CW-1:0] column_count;
  logic [1:0]    col_mod3;
  logic [1:0]    row_phase;
  logic          first_row;
  logic [7:0]    left_luma;

  logic          s1_valid;
  logic [7:0]    s1_red;
  logic [7:0]    s1_green;
  logic [7:0]    s1_blue;
  logic [CW-1:0] s1_col;
  logic          s1_col_zero;
  logic          s1_first;
  rpf_pkg::pos_t s1_pos;

  logic          s2_valid;
  rpf_pkg::nbr_t s2_nbr;
  rpf_pkg::pos_t s2_pos;

  logic out_free;
  logic s2_free;
  logic s2_adv;
  logic s1_free;
  logic s1_adv;
  logic in_acc;

  logic [WW-1:0] width_eff;
  logic [CW-1:0] col_now;
  logic [1:0]    mod3_now;
  logic [1:0]    phase_now;
  logic          first_now;
  logic [WW-1:0] col_inc;
  logic          row_end;
  logic [CW-1:0] column_count_next;
  logic [1:0]    col_mod3_next;
  logic [1:0]    row_phase_next;

  logic [7:0] term_r;
  logic [7:0] term_g;
  logic [7:0] term_b;
  logic [9:0] lum_sum;
  logic [7:0] lum;
  logic [7:0] above_raw;

  rpf_pkg::lane_t lane_r;
  rpf_pkg::lane_t lane_g;
  rpf_pkg::lane_t lane_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= rpf_pkg::MODE_RESET;
      image_width    <= rpf_pkg::WIDTH_RESET;
      max_color      <= rpf_pkg::MAX_COLOR_RESET;
      edge_threshold <= rpf_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rpf_pkg::CFG_MODE:      mode           <= cfg_data[3:0];
        rpf_pkg::CFG_WIDTH:     image_width    <= cfg_data;
        rpf_pkg::CFG_MAX_COLOR: max_color      <= cfg_data[7:0];
        rpf_pkg::CFG_THRESHOLD: edge_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_free = !res_valid || !res_stall;
    s2_adv   = s2_valid && out_free;
    s2_free  = !s2_valid || out_free;
    s1_adv   = s1_valid && s2_free;
    s1_free  = !s1_valid || s2_free;
    px_stall = !s1_free;
    in_acc   = px_valid && s1_free;
  end

  always_comb begin
    if (image_width == 11'd0) begin
      width_eff = WW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(image_width);
    end

    col_now   = px.frame_start ? '0 : column_count;
    mod3_now  = px.frame_start ? 2'd0 : col_mod3;
    phase_now = px.frame_start ? 2'd0 : row_phase;
    first_now = px.frame_start ? 1'b1 : first_row;

    col_inc = WW'(col_now) + WW'(1);
    row_end = col_inc >= width_eff;

    if (row_end) begin
      column_count_next = '0;
      col_mod3_next     = 2'd0;
      row_phase_next    = (phase_now >= 2'd2) ? 2'd0 : phase_now + 2'd1;
    end else begin
      column_count_next = CW'(col_inc);
      col_mod3_next     = (mod3_now >= 2'd2) ? 2'd0 : mod3_now + 2'd1;
      row_phase_next    = phase_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      col_mod3     <= 2'd0;
      row_phase    <= 2'd0;
      first_row    <= 1'b1;
    end else if (in_acc) begin
      column_count <= column_count_next;
      col_mod3     <= col_mod3_next;
      row_phase    <= row_phase_next;
      first_row    <= first_now && !row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_red            <= px.red_in;
      s1_green          <= px.green_in;
      s1_blue           <= px.blue_in;
      s1_col            <= col_now;
      s1_col_zero       <= (col_now == '0);
      s1_first          <= first_now;
      s1_pos.col_odd    <= col_now[0];
      s1_pos.grid_keep  <= (mod3_now == 2'd0) && (phase_now == 2'd0);
    end
  end

  rpf_lane u_lane_r (
    .clk       (clk),
    .load      (s1_adv),
    .x         (s1_red),
    .coef      (rpf_pkg::LUMA_R_Q16),
    .max_color (max_color),
    .term      (term_r),
    .q         (lane_r)
  );

  rpf_lane u_lane_g (
    .clk       (clk),
    .load      (s1_adv),
    .x         (s1_green),
    .coef      (rpf_pkg::LUMA_G_Q16),
    .max_color (max_color),
    .term      (term_g),
    .q         (lane_g)
  );

  rpf_lane u_lane_b (
    .clk       (clk),
    .load      (s1_adv),
    .x         (s1_blue),
    .coef      (rpf_pkg::LUMA_B_Q16),
    .max_color (max_color),
    .term      (term_b),
    .q         (lane_b)
  );

  assign lum_sum = 10'(term_r) + 10'(term_g) + 10'(term_b);
  assign lum     = lum_sum[7:0];

  rpf_linestore #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_linestore (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_now),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (lum),
    .rd_data (above_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_luma <= 8'd0;
    end else if (s1_adv) begin
      left_luma <= lum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_nbr.lum   <= lum;
      s2_nbr.left  <= s1_col_zero ? 8'd0 : left_luma;
      s2_nbr.above <= s1_first ? 8'd0 : above_raw;
      s2_pos       <= s1_pos;
    end
  end

  rpf_merge u_merge (
    .clk            (clk),
    .load           (s2_adv),
    .mode           (mode),
    .max_color      (max_color),
    .edge_threshold (edge_threshold),
    .red            (lane_r),
    .green          (lane_g),
    .blue           (lane_b),
    .nbr            (s2_nbr),
    .pos            (s2_pos),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    (px_valid && !px_stall) |=> s1_valid)
    else $error("accepted request did not enter the first stage");

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall && s2_valid && s1_valid) |-> px_stall)
    else $error("request taken while every stage is full and the output is stalled");

  a_result_from_s2: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s2_valid))
    else $error("result appeared with no item in the second stage");

  a_counters_in_range: assert property (@(posedge clk) disable iff (rst)
    (row_phase != 2'd3) && (col_mod3 != 2'd3))
    else $error("row phase or column modulo counter out of range");
`endif

endmodule

`default_nettype wire
